// ----- src/tca_pkg.sv -----
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants for the touch count trimmed accumulator.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int unsigned SampleCountW = 8;
  localparam int unsigned TimeoutW     = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned TotalW       = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned ReadingW     = 24;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned CfgDataW     = 32;

  localparam int unsigned MaxSamplesDefault = 32;

  localparam logic [SampleCountW-1:0] SampleCountReset = 8'd1;
  localparam logic [TimeoutW-1:0]     TimeoutReset     = 32'd1250000;

  // x / 1000 == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int unsigned ReadingDivisor = 1000;
  localparam int unsigned RecipShift     = 38;
  localparam int unsigned RecipW         = 29;
  localparam logic [RecipW-1:0] RecipMult =
    RecipW'(((64'd1 << RecipShift) + 64'(ReadingDivisor) - 64'd1) / 64'(ReadingDivisor));

  localparam logic [ReadingW-1:0] MinStart = 24'hFFFFFF;
  localparam logic [SampleCountW:0] RunExtra = 9'd2;

  typedef enum logic [CfgIdxW-1:0] {
    RegSampleCount = 8'd0,
    RegTimeout     = 8'd1
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusTimeout = 2'd1,
    StatusTooMany = 2'd2
  } status_e;

  typedef struct packed {
    logic                timeout;
    logic [ReadingW-1:0] reading;
  } reading_t;

  typedef struct packed {
    logic              emit;
    status_e           status;
    logic [TotalW-1:0] total;
  } result_t;

endpackage

// ----- src/tca_reading.sv -----
// ----------------------------------------------------------------------------
// tca_reading
// Elapsed cycles from the countdown value and the reading (elapsed / 1000).
// ----------------------------------------------------------------------------
module tca_reading import tca_pkg::*; (
  input  logic [TimeoutW-1:0] timeout_cycles_i,
  input  logic [CountW-1:0]   remaining_count_i,
  output reading_t            reading_o
);

  logic [CountW-1:0]        elapsed;
  logic [CountW+RecipW-1:0] product;

  assign elapsed = timeout_cycles_i - remaining_count_i;
  assign product = (CountW+RecipW)'(elapsed) * (CountW+RecipW)'(RecipMult);

  assign reading_o.timeout = (elapsed == '0);
  assign reading_o.reading = ReadingW'(product >> RecipShift);

endmodule

// ----- src/tca_accum.sv -----
// ----------------------------------------------------------------------------
// tca_accum
// Run state: sum, min and max of readings, and the trimmed total per run.
// ----------------------------------------------------------------------------
module tca_accum import tca_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [SampleCountW-1:0] sample_count_i,
  input  reading_t                rd_i,
  output result_t                 res_o
);

  localparam int unsigned TakenW = $clog2(MaxSamples + 3);
  localparam int unsigned RunW   = (TakenW > SampleCountW + 1) ? TakenW : SampleCountW + 1;

  logic [TotalW-1:0]   sum_q, sum_d, sum_new;
  logic [ReadingW-1:0] min_q, min_d, min_new;
  logic [ReadingW-1:0] max_q, max_d, max_new;
  logic [TakenW-1:0]   taken_q, taken_d, taken_new;
  logic [RunW-1:0]     run_len;
  logic                too_many, single, done;

  assign too_many  = sample_count_i > SampleCountW'(MaxSamples);
  assign single    = (sample_count_i == SampleCountW'(1));
  assign sum_new   = sum_q + TotalW'(rd_i.reading);
  assign min_new   = (rd_i.reading < min_q) ? rd_i.reading : min_q;
  assign max_new   = (rd_i.reading > max_q) ? rd_i.reading : max_q;
  assign taken_new = taken_q + TakenW'(1);
  assign run_len   = RunW'(sample_count_i) + RunW'(RunExtra);
  assign done      = RunW'(taken_new) >= run_len;

  always_comb begin
    res_o.emit   = 1'b1;
    res_o.status = StatusOk;
    res_o.total  = '0;
    sum_d        = '0;
    min_d        = MinStart;
    max_d        = '0;
    taken_d      = '0;
    if (too_many) begin
      res_o.status = StatusTooMany;
    end else if (rd_i.timeout) begin
      res_o.status = StatusTimeout;
    end else if (single) begin
      res_o.total = TotalW'(rd_i.reading);
    end else if (done) begin
      res_o.total = sum_new - TotalW'(min_new) - TotalW'(max_new);
    end else begin
      res_o.emit = 1'b0;
      sum_d      = sum_new;
      min_d      = min_new;
      max_d      = max_new;
      taken_d    = taken_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      min_q   <= MinStart;
      max_q   <= '0;
      taken_q <= '0;
    end else if (en_i) begin
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      taken_q <= taken_d;
    end
  end

endmodule

// ----- src/touch_count_trimmed_accumulator.sv -----
// ----------------------------------------------------------------------------
// touch_count_trimmed_accumulator
// Turns capacitive countdown values into readings and olympic trimmed sums.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | remaining_count
//  out     | output    | out_valid/out_ready | status, total
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while the output does not stall; an accepted item goes
//  through the input register, reading register and output register, in order.
//  The 32x29 reciprocal multiply in front of the reading register sets the clock.
//  Items that only extend a run give no result. cfg_ready is always high.
//  Reset: sample_count 1, timeout 1250000, empty run, pipeline empty.
//  A stalled output holds its item; the reading stage backs up behind it.
// ----------------------------------------------------------------------------
module touch_count_trimmed_accumulator import tca_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CountW-1:0]   remaining_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [TotalW-1:0]   total_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [SampleCountW-1:0] sample_count_q;
  logic [TimeoutW-1:0]     timeout_q;
  logic                    in_v_q;
  logic [CountW-1:0]       rem_q;
  logic                    rd_v_q;
  reading_t                rd_q, rd_d;
  logic                    out_v_q;
  status_e                 status_q;
  logic [TotalW-1:0]       total_q;
  result_t                 res;
  logic                    out_free, rd_free, rd_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SampleCountReset;
      timeout_q      <= TimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSampleCount: sample_count_q <= cfg_data_i[SampleCountW-1:0];
        RegTimeout:     timeout_q      <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_v_q || out_ready_i;
  assign rd_adv     = rd_v_q && out_free;
  assign rd_free    = !rd_v_q || out_free;
  assign in_ready_o = !in_v_q || rd_free;

  tca_reading u_reading (
    .timeout_cycles_i  (timeout_q),
    .remaining_count_i (rem_q),
    .reading_o         (rd_d)
  );

  tca_accum #(
    .MaxSamples (MaxSamples)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (rd_adv),
    .sample_count_i (sample_count_q),
    .rd_i           (rd_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (rd_free)    rd_v_q <= in_v_q;
      if (rd_adv && res.emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) rem_q <= remaining_count_i;
    if (rd_free && in_v_q)        rd_q  <= rd_d;
    if (rd_adv && res.emit) begin
      status_q <= res.status;
      total_q  <= res.total;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = status_q;
  assign total_o     = total_q;

  // error results always carry a zero total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StatusOk || total_o == '0))
    else $error("error status with nonzero total");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_adv && out_v_q) |-> out_ready_i)
    else $error("output register overwritten");

  // input only stalls when the input register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_v_q && rd_v_q && out_v_q && !out_ready_i))
    else $error("input stalled without backpressure");

endmodule
